// ===== hdl/rcpd_pkg.sv =====
// Shared types and constants for the remote command packet decoder.
package rcpd_pkg;

  localparam int unsigned PACKET_BYTES = 8;
  localparam int unsigned COUNT_W      = 4;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 4'd15;
  localparam logic [COUNT_W-1:0] COUNT_FULL = 4'(PACKET_BYTES - 1);
  localparam int unsigned QUEUE_DEPTH  = 2;

  // Register index, taken from paddr[2].
  localparam logic REG_MAX_CHANNEL = 1'b0;
  localparam logic REG_TYPE_MARKER = 1'b1;
  localparam logic [7:0] MAX_CHANNEL_RST = 8'd3;
  localparam logic [7:0] TYPE_MARKER_RST = 8'h20;

  // Opcodes (byte 4 with top bit removed).
  localparam logic [6:0] OP_SWITCH = 7'd1;
  localparam logic [6:0] OP_HUE    = 7'd2;
  localparam logic [6:0] OP_TEMP   = 7'd3;
  localparam logic [6:0] OP_LEVEL  = 7'd4;
  localparam logic [6:0] OP_MODE   = 7'd5;

  localparam logic [7:0] ARG_SPEED_DOWN  = 8'h0B;
  localparam logic [7:0] ARG_SPEED_UP    = 8'h0A;
  localparam logic [7:0] ON_GROUPS       = 8'd5;
  localparam logic [7:0] HUE_OFFSET      = 8'h5F;
  localparam logic [7:0] TEMP_OFFSET     = 8'(8'hCC - 8'd20);
  localparam logic [7:0] TEMP_FLOOR      = 8'd20;
  localparam logic [7:0] TEMP_SPAN       = 8'd200;
  localparam logic [7:0] TEMP_TOP        = 8'(TEMP_FLOOR + TEMP_SPAN);
  localparam logic [7:0] BRIGHT_THRESH   = 8'h80;
  localparam logic [7:0] BRIGHT_OFFSET   = 8'h8F;
  localparam logic [7:0] SAT_OFFSET      = 8'h0D;
  localparam logic [7:0] LEVEL_MAX       = 8'd100;
  localparam logic [7:0] HUE_FULL        = 8'hFF;

  // floor(x / 25) for x < 2**21 by reciprocal multiply.
  localparam int unsigned DIV25_SHIFT = 27;
  localparam logic [22:0] DIV25_MUL   = 23'd5368710;

  typedef enum logic [3:0] {
    CMD_NIGHT      = 4'd0,
    CMD_SPEED_DOWN = 4'd1,
    CMD_SPEED_UP   = 4'd2,
    CMD_ON         = 4'd3,
    CMD_OFF        = 4'd4,
    CMD_HUE        = 4'd5,
    CMD_TEMP       = 4'd6,
    CMD_BRIGHT     = 4'd7,
    CMD_SAT        = 4'd8,
    CMD_MODE       = 4'd9
  } cmd_t;

  // One finished packet, handed from the front end to the decoder.
  typedef struct packed {
    logic        hdr_ok;   // length, channel and type all good
    logic [15:0] remote_addr;
    logic [7:0]  opcode;   // byte 4, top bit = night flag
    logic [7:0]  arg;      // byte 5
    logic [7:0]  group;    // byte 7
  } pkt_rec_t;

  function automatic logic [16:0] div25(input logic [20:0] x);
    logic [43:0] p;
    p = 44'(x) * 44'(DIV25_MUL);
    return p[43:DIV25_SHIFT];
  endfunction

endpackage

// ===== hdl/rcpd_if.sv =====
// Byte input and decoded result channel interfaces.
interface rcpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rcpd_out_if;
  logic        valid;
  logic        ready;
  logic        packet_ok;
  logic [15:0] remote_addr;
  logic [7:0]  group_num;
  logic [3:0]  command_code;
  logic [23:0] argument;

  modport source (output valid, output packet_ok, output remote_addr, output group_num,
                  output command_code, output argument, input ready);
  modport sink   (input valid, input packet_ok, input remote_addr, input group_num,
                  input command_code, input argument, output ready);
endinterface

// ===== hdl/rcpd_front.sv =====
// Front end: byte store, saturating count and header check per packet.
module rcpd_front (
  input  logic               clk,
  input  logic               rst,
  rcpd_in_if.sink            pkt,
  input  logic [7:0]         max_channel,
  input  logic [7:0]         type_marker,
  input  logic               q_full,
  output logic               q_push,
  output rcpd_pkg::pkt_rec_t q_data
);

  logic [rcpd_pkg::COUNT_W-1:0] byte_count;
  logic [7:0] store [rcpd_pkg::PACKET_BYTES];
  logic accept;

  assign pkt.ready = !q_full;
  assign accept    = pkt.valid && pkt.ready;
  assign q_push    = accept && pkt.last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (accept) begin
      if (pkt.last_byte) begin
        byte_count <= '0;
      end else if (byte_count != rcpd_pkg::COUNT_MAX) begin
        byte_count <= byte_count + 1'b1;
      end
    end
  end

  // Payload store: bytes past the packet length are dropped.
  always_ff @(posedge clk) begin
    if (accept && !byte_count[rcpd_pkg::COUNT_W-1]) begin
      store[byte_count[rcpd_pkg::COUNT_W-2:0]] <= pkt.data_byte;
    end
  end

  // Final byte arrives with the count at 7: bytes 0..6 are already held.
  always_comb begin
    q_data.hdr_ok      = (byte_count == rcpd_pkg::COUNT_FULL) &&
                         (store[0] <= max_channel) && (store[1] == type_marker);
    q_data.remote_addr = {store[2], store[3]};
    q_data.opcode      = store[4];
    q_data.arg         = store[5];
    q_data.group       = pkt.data_byte;
  end

  a_count_clear: assert property (@(posedge clk) disable iff (rst)
    q_push |=> byte_count == '0)
    else $error("byte count not cleared after final byte");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    accept && !pkt.last_byte && byte_count != rcpd_pkg::COUNT_MAX
      |=> byte_count == $past(byte_count) + 1'b1)
    else $error("byte count did not advance");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> byte_count == $past(byte_count))
    else $error("byte count moved without a beat");

endmodule

// ===== hdl/rcpd_queue.sv =====
// Short queue of finished packets between front end and decoder.
module rcpd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rcpd_pkg::pkt_rec_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output rcpd_pkg::pkt_rec_t head_data
);

  localparam int unsigned PTR_W = $clog2(rcpd_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(rcpd_pkg::QUEUE_DEPTH + 1);

  rcpd_pkg::pkt_rec_t entry [rcpd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic do_push;
  logic do_pop;

  assign full       = (fill == CNT_W'(rcpd_pkg::QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_data  = entry[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(rcpd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(rcpd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(rcpd_pkg::QUEUE_DEPTH))
    else $error("queue fill out of range");

  a_fill_up: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> fill == $past(fill) + 1'b1)
    else $error("queue fill did not rise on push");

endmodule

// ===== hdl/rcpd_back.sv =====
// Back end: command decode, argument scaling and result register.
module rcpd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  rcpd_pkg::pkt_rec_t head_data,
  output logic               pop,
  rcpd_out_if.source         res
);

  logic        ok;
  logic [15:0] rid;
  logic [7:0]  grp;
  rcpd_pkg::cmd_t code;
  logic [23:0] arg_q;
  logic [7:0]  a;
  logic [6:0]  op;
  logic [7:0]  hue_n;
  logic [7:0]  temp_t;
  logic [7:0]  temp_v;
  logic [7:0]  lvl_d;
  logic [7:0]  lvl;
  logic [20:0] div_x;
  logic        use_div;
  logic [16:0] div_q;

  assign a  = head_data.arg;
  assign op = head_data.opcode[6:0];
  assign hue_n  = a - rcpd_pkg::HUE_OFFSET;
  assign temp_t = a - rcpd_pkg::TEMP_OFFSET;
  assign div_q  = rcpd_pkg::div25(div_x);

  always_comb begin
    ok      = head_data.hdr_ok;
    rid     = head_data.remote_addr;
    grp     = head_data.group;
    code    = rcpd_pkg::CMD_NIGHT;
    arg_q   = '0;
    div_x   = '0;
    use_div = 1'b0;
    temp_v  = '0;
    lvl_d   = '0;
    lvl     = '0;
    case (op)
      rcpd_pkg::OP_SWITCH: begin
        if (head_data.opcode[7]) begin
          code = rcpd_pkg::CMD_NIGHT;
        end else if (a == rcpd_pkg::ARG_SPEED_DOWN) begin
          code = rcpd_pkg::CMD_SPEED_DOWN;
        end else if (a == rcpd_pkg::ARG_SPEED_UP) begin
          code = rcpd_pkg::CMD_SPEED_UP;
        end else if (a < rcpd_pkg::ON_GROUPS) begin
          code = rcpd_pkg::CMD_ON;
          grp  = a;
        end else begin
          code = rcpd_pkg::CMD_OFF;
          grp  = a - rcpd_pkg::ON_GROUPS;
        end
      end
      rcpd_pkg::OP_HUE: begin
        // n * 65536 / 255 = 257n, plus one when n is 255
        code  = rcpd_pkg::CMD_HUE;
        arg_q = {8'd0, hue_n, hue_n} + 24'(hue_n == rcpd_pkg::HUE_FULL);
      end
      rcpd_pkg::OP_TEMP: begin
        code = rcpd_pkg::CMD_TEMP;
        if (temp_t < rcpd_pkg::TEMP_FLOOR) begin
          temp_v = '0;
        end else if (temp_t > rcpd_pkg::TEMP_TOP) begin
          temp_v = rcpd_pkg::TEMP_SPAN;
        end else begin
          temp_v = temp_t - rcpd_pkg::TEMP_FLOOR;
        end
        // (200 - v) * 65536 / 200 = (200 - v) * 8192 / 25
        div_x   = {rcpd_pkg::TEMP_SPAN - temp_v, 13'd0};
        use_div = 1'b1;
      end
      rcpd_pkg::OP_LEVEL: begin
        if (a >= rcpd_pkg::BRIGHT_THRESH) begin
          code = rcpd_pkg::CMD_BRIGHT;
          lvl_d = (a < rcpd_pkg::BRIGHT_OFFSET) ? 8'd0 : a - rcpd_pkg::BRIGHT_OFFSET;
        end else begin
          code = rcpd_pkg::CMD_SAT;
          lvl_d = (a < rcpd_pkg::SAT_OFFSET) ? 8'd0 : a - rcpd_pkg::SAT_OFFSET;
        end
        lvl = (lvl_d > rcpd_pkg::LEVEL_MAX) ? rcpd_pkg::LEVEL_MAX : lvl_d;
        // lvl * 65536 / 100 = lvl * 16384 / 25
        div_x   = {lvl[6:0], 14'd0};
        use_div = 1'b1;
      end
      rcpd_pkg::OP_MODE: begin
        code  = rcpd_pkg::CMD_MODE;
        arg_q = {a, 16'd0};
      end
      default: begin
        ok  = 1'b0;
      end
    endcase
    if (use_div) begin
      arg_q = 24'(div_q);
    end
    if (!ok) begin
      rid   = '0;
      grp   = '0;
      code  = rcpd_pkg::CMD_NIGHT;
      arg_q = '0;
    end
  end

  assign pop = head_valid && (!res.valid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (pop) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.packet_ok    <= ok;
      res.remote_addr  <= rid;
      res.group_num    <= grp;
      res.command_code <= code;
      res.argument     <= arg_q;
    end
  end

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.packet_ok |-> res.remote_addr == '0 && res.group_num == '0 &&
      res.command_code == '0 && res.argument == '0)
    else $error("rejected result carries non-zero fields");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.command_code <= rcpd_pkg::CMD_MODE)
    else $error("command code out of range");

  a_pop_loads: assert property (@(posedge clk) disable iff (rst)
    pop |=> res.valid)
    else $error("popped packet not shown as a result");

  a_arg_bound: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.command_code != rcpd_pkg::CMD_MODE |-> res.argument <= 24'h010000)
    else $error("fractional argument above one");

endmodule

// ===== hdl/remote_command_packet_decoder.sv =====
// Top level of the remote command packet decoder with its APB register port.
// Throughput: one byte beat per cycle while the packet queue is not full, with no
// gaps between packets. A finished packet is written into the packet queue, then
// loaded into the result register in the decoder once that register is free.
// The two-entry packet queue lets the byte side run while a result waits.
// Reset (rst, synchronous): byte count, queue and result valid cleared,
// max_channel to 3 and type_marker to 0x20.
module remote_command_packet_decoder (
  input  logic        clk,
  input  logic        rst,
  rcpd_in_if.sink     pkt,
  rcpd_out_if.source  res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] max_channel;
  logic [7:0] type_marker;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  rcpd_pkg::pkt_rec_t q_in;
  rcpd_pkg::pkt_rec_t q_head;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_channel <= rcpd_pkg::MAX_CHANNEL_RST;
      type_marker <= rcpd_pkg::TYPE_MARKER_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == rcpd_pkg::REG_TYPE_MARKER) begin
        type_marker <= pwdata[7:0];
      end else begin
        max_channel <= pwdata[7:0];
      end
    end
  end

  assign prdata = (paddr[2] == rcpd_pkg::REG_TYPE_MARKER) ? {24'd0, type_marker}
                                                          : {24'd0, max_channel};

  rcpd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .pkt         (pkt),
    .max_channel (max_channel),
    .type_marker (type_marker),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  rcpd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  rcpd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head_data  (q_head),
    .pop        (q_pop),
    .res        (res)
  );

endmodule

// ===== tb/sv/remote_command_packet_decoder_tb.sv =====
// Self-checking testbench for the remote command packet decoder.
`timescale 1ns / 1ps

module remote_command_packet_decoder_tb;

  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned SETTLE       = 4;
  localparam logic [2:0]  MAX_CHANNEL_ADDR = {rcpd_pkg::REG_MAX_CHANNEL, 2'b00};
  localparam logic [2:0]  TYPE_MARKER_ADDR = {rcpd_pkg::REG_TYPE_MARKER, 2'b00};

  // argument bytes sitting on the decode boundaries
  localparam logic [7:0] EDGE_ARGS [0:31] = '{
    8'h00, 8'h01, 8'h04, 8'h05, 8'h06, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E,
    8'h5E, 8'h5F, 8'h60, 8'h70, 8'h71, 8'h72, 8'h7F, 8'h80, 8'h8E, 8'h8F, 8'h90,
    8'hF2, 8'hF3, 8'hF4, 8'hB8, 8'hCB, 8'hCC, 8'hCD, 8'h94, 8'h95, 8'hFF
  };

  typedef logic [7:0] pkt_bytes_t [$];

  typedef struct packed {
    logic           packet_ok;
    logic [15:0]    remote_addr;
    logic [7:0]     group_num;
    rcpd_pkg::cmd_t command_code;
    logic [23:0]    argument;
  } decoded_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rcpd_in_if  pkt_if ();
  rcpd_out_if res_if ();

  remote_command_packet_decoder dut (
    .clk     (clk),
    .rst     (rst),
    .pkt     (pkt_if),
    .res     (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state and register copies
  logic [3:0]  rx_count;
  logic [7:0]  rx_bytes [0:rcpd_pkg::PACKET_BYTES-1];
  logic [7:0]  cfg_max_channel;
  logic [7:0]  cfg_type_marker;
  decoded_t    pending_results [$];

  int unsigned mismatches;
  int unsigned bytes_sent;
  int unsigned cycle_count;
  logic        no_gaps;
  int unsigned hold_seq;
  int unsigned hold_seen;
  int unsigned sink_stall;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [23:0] q16_ratio(input int unsigned num, input int unsigned den);
    return 24'((num << 16) / den);
  endfunction

  function automatic int unsigned clamp_level(input int val, input int top);
    if (val < 0) return 0;
    if (val > top) return top;
    return val;
  endfunction

  // Takes one accepted byte; on the last byte queues the decoded result.
  task automatic predict_decode(input logic [7:0] b, input logic last);
    decoded_t    d;
    logic [7:0]  full;
    logic [7:0]  a;
    int unsigned v;
    if (rx_count < 4'(rcpd_pkg::PACKET_BYTES)) rx_bytes[rx_count[2:0]] = b;
    if (rx_count != rcpd_pkg::COUNT_MAX) rx_count = rx_count + 4'd1;
    if (!last) return;
    d = '0;
    if (rx_count == 4'(rcpd_pkg::PACKET_BYTES) && rx_bytes[0] <= cfg_max_channel &&
        rx_bytes[1] == cfg_type_marker) begin
      full = rx_bytes[4];
      a    = rx_bytes[5];
      d.packet_ok   = 1'b1;
      d.remote_addr = {rx_bytes[2], rx_bytes[3]};
      d.group_num   = rx_bytes[7];
      case (full[6:0])
        rcpd_pkg::OP_SWITCH: begin
          if (full[7]) d.command_code = rcpd_pkg::CMD_NIGHT;
          else if (a == 8'h0B) d.command_code = rcpd_pkg::CMD_SPEED_DOWN;
          else if (a == 8'h0A) d.command_code = rcpd_pkg::CMD_SPEED_UP;
          else if (a < 8'd5) begin
            d.command_code = rcpd_pkg::CMD_ON;
            d.group_num    = a;
          end else begin
            d.command_code = rcpd_pkg::CMD_OFF;
            d.group_num    = a - 8'd5;
          end
        end
        rcpd_pkg::OP_HUE: begin
          d.command_code = rcpd_pkg::CMD_HUE;
          d.argument     = q16_ratio(8'(a - 8'h5F), 255);
        end
        rcpd_pkg::OP_TEMP: begin
          // distance from 0xCC, wrapped, then clamped to 0..200
          v = clamp_level(int'(8'(a - 8'hB8)) - 20, 200);
          d.command_code = rcpd_pkg::CMD_TEMP;
          d.argument     = q16_ratio(200 - v, 200);
        end
        rcpd_pkg::OP_LEVEL: begin
          if (a >= 8'h80) begin
            d.command_code = rcpd_pkg::CMD_BRIGHT;
            d.argument     = q16_ratio(clamp_level(int'(a) - 'h8F, 100), 100);
          end else begin
            d.command_code = rcpd_pkg::CMD_SAT;
            d.argument     = q16_ratio(clamp_level(int'(a) - 'h0D, 100), 100);
          end
        end
        rcpd_pkg::OP_MODE: begin
          d.command_code = rcpd_pkg::CMD_MODE;
          d.argument     = {a, 16'h0000};
        end
        default: d = '0;
      endcase
    end
    rx_count = 4'd0;
    pending_results.push_back(d);
  endtask

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    decoded_t want;
    if (rst) begin
      rx_count = 4'd0;
    end else begin
      if (pkt_if.valid && pkt_if.ready) predict_decode(pkt_if.data_byte, pkt_if.last_byte);
      if (res_if.valid && res_if.ready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("packet_ok", want.packet_ok, res_if.packet_ok);
          check_field("remote_addr", want.remote_addr, res_if.remote_addr);
          check_field("group_num", want.group_num, res_if.group_num);
          check_field("command_code", want.command_code, res_if.command_code);
          check_field("argument", want.argument, res_if.argument);
        end
      end
    end
  end

  // result side: random stalls, plus a long hold on request
  always @(posedge clk) begin : result_sink
    int unsigned g;
    if (rst) begin
      res_if.ready <= 1'b0;
      sink_stall   <= 0;
      hold_seen    <= 0;
    end else if (hold_seq != hold_seen) begin
      hold_seen    <= hold_seq;
      sink_stall   <= LONG_HOLD - 1;
      res_if.ready <= 1'b0;
    end else if (sink_stall != 0) begin
      sink_stall   <= sink_stall - 1;
      res_if.ready <= 1'b0;
    end else if (no_gaps) begin
      res_if.ready <= 1'b1;
    end else begin
      g = pick_gap();
      res_if.ready <= (g == 0);
      if (g > 1) sink_stall <= g - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[remote_command_packet_decoder] ERROR");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      pkt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pkt_if.valid     <= 1'b1;
    pkt_if.data_byte <= b;
    pkt_if.last_byte <= last;
    @(posedge clk);
    while (!pkt_if.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_packet(input pkt_bytes_t p);
    foreach (p[i]) send_byte(p[i], i == p.size() - 1);
  endtask

  // sender stops and waits for every outstanding result
  task automatic drain_results();
    pkt_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {24'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == MAX_CHANNEL_ADDR) cfg_max_channel = val;
    else cfg_type_marker = val;
    @(posedge clk);
  endtask

  task automatic reg_check(input logic [2:0] addr, input logic [7:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field("prdata", want, prdata[7:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_arg();
    if ($urandom_range(0, 1) == 0) return EDGE_ARGS[$urandom_range(0, 31)];
    return 8'($urandom);
  endfunction

  // mostly well-formed packets; some of wrong length, channel, type or opcode
  function automatic pkt_bytes_t random_packet();
    pkt_bytes_t  p;
    int unsigned kind;
    int unsigned len;
    logic [6:0]  op;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      len = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 7) : $urandom_range(9, 20);
      repeat (len) p.push_back(8'($urandom));
      return p;
    end
    if (kind < 13 && cfg_max_channel != 8'hFF)
      p.push_back(8'($urandom_range(int'(cfg_max_channel) + 1, 255)));
    else if ($urandom_range(0, 3) == 0)
      p.push_back(cfg_max_channel);
    else
      p.push_back(8'($urandom_range(0, cfg_max_channel)));
    if (kind >= 13 && kind < 18) p.push_back(cfg_type_marker ^ 8'($urandom_range(1, 255)));
    else p.push_back(cfg_type_marker);
    p.push_back(8'($urandom));
    p.push_back(8'($urandom));
    if (kind >= 18 && kind < 24) begin
      op = 7'($urandom_range(6, 127));
      if ($urandom_range(0, 3) == 0) op = 7'd0;
    end else begin
      op = 7'($urandom_range(rcpd_pkg::OP_SWITCH, rcpd_pkg::OP_MODE));
    end
    p.push_back({1'($urandom), op});
    p.push_back(pick_arg());
    p.push_back(8'($urandom));
    p.push_back(8'($urandom));
    return p;
  endfunction

  task automatic run_phase(input logic [7:0] max_channel, input logic [7:0] marker,
                           input int unsigned budget);
    int unsigned stop_at;
    reg_write(MAX_CHANNEL_ADDR, max_channel);
    reg_write(TYPE_MARKER_ADDR, marker);
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) send_packet(random_packet());
    drain_results();
  endtask

  task automatic test_register_access();
    reg_check(MAX_CHANNEL_ADDR, 8'd3);
    reg_check(TYPE_MARKER_ADDR, 8'h20);
    reg_write(MAX_CHANNEL_ADDR, 8'hFF);
    reg_write(TYPE_MARKER_ADDR, 8'h00);
    reg_check(MAX_CHANNEL_ADDR, 8'hFF);
    reg_check(TYPE_MARKER_ADDR, 8'h00);
    reg_write(MAX_CHANNEL_ADDR, 8'd3);
    reg_write(TYPE_MARKER_ADDR, 8'h20);
  endtask

  task automatic test_directed_packets();
    pkt_bytes_t p;
    p = {8'hFF};                      // lone last byte: too short
    send_packet(p);
    p = {8'h03, 8'h20, 8'hFF, 8'hFF, 8'h85, 8'hFF, 8'h00, 8'hFF};  // mode at channel limit
    send_packet(p);
    p = {8'h00, 8'h20, 8'h00, 8'h00, 8'h81, 8'h00, 8'hFF, 8'h00};  // night
    send_packet(p);
    p = {8'h00, 8'h20, 8'h01, 8'h02, 8'h01, 8'h02, 8'h00, 8'h00, 8'h00};  // one too many
    send_packet(p);
    drain_results();
  endtask

  task automatic test_config_sweep();
    run_phase(8'd3, 8'h20, 240);
    run_phase(8'd0, 8'h00, 240);
    run_phase(8'hFF, 8'hFF, 240);
    run_phase(8'hFF, 8'h00, 240);
    run_phase(8'd0, 8'hFF, 240);
    run_phase(8'($urandom), 8'($urandom), 240);
    run_phase(8'($urandom_range(0, 15)), 8'($urandom), 240);
  endtask

  // sink holds off while full-rate packets keep coming, so the input stalls
  task automatic test_back_pressure();
    pkt_bytes_t p;
    reg_write(MAX_CHANNEL_ADDR, 8'd3);
    reg_write(TYPE_MARKER_ADDR, 8'h20);
    no_gaps  <= 1'b1;
    hold_seq <= hold_seq + 1;
    repeat (6) begin
      p = {8'($urandom_range(0, 3)), 8'h20, 8'($urandom), 8'($urandom),
           {1'b0, 7'($urandom_range(rcpd_pkg::OP_SWITCH, rcpd_pkg::OP_MODE))}, pick_arg(),
           8'($urandom), 8'($urandom)};
      send_packet(p);
    end
    drain_results();
  endtask

  task automatic test_full_rate();
    no_gaps <= 1'b1;
    run_phase(8'd7, 8'h5A, 200);
    no_gaps <= 1'b0;
  endtask

  initial begin
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    pkt_if.valid     = 1'b0;
    pkt_if.data_byte = '0;
    pkt_if.last_byte = 1'b0;
    cfg_max_channel  = rcpd_pkg::MAX_CHANNEL_RST;
    cfg_type_marker  = rcpd_pkg::TYPE_MARKER_RST;
    no_gaps          = 1'b0;
    hold_seq         = 0;
    mismatches       = 0;
    bytes_sent       = 0;
    cycle_count      = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_access();
    test_directed_packets();
    test_config_sweep();
    test_back_pressure();
    test_full_rate();
    drain_results();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[remote_command_packet_decoder] OK");
    end else begin
      $display("[remote_command_packet_decoder] ERROR");
    end
    $finish;
  end

endmodule
